/* sv/sfs_pkg.sv */
package sfs_pkg;

	// Sizing of the flow stack and the address path
	localparam int STACK_DEPTH = 8;
	localparam int ADDR_W      = 32;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int COUNT_W     = 16;

	// Variable-length number decoding
	localparam int NUM_W       = 28;
	localparam int NUM_BYTES_W = 3;
	localparam int MAX_NUM_BYTES = 4;

	typedef enum logic [2:0] {
		ACT_RESTART    = 3'd0,
		ACT_CALL       = 3'd1,
		ACT_LOOP_START = 3'd2,
		ACT_LOOP_END   = 3'd3,
		ACT_RETURN     = 3'd4,
		ACT_NUMBER     = 3'd5
	} action_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [ADDR_W-1:0]  jump_offset;
		logic [COUNT_W-1:0] loop_count;
		logic [7:0]         data_byte;
	} in_item_t;

	typedef struct packed {
		logic              accepted;
		logic [ADDR_W-1:0] position;
		logic [NUM_W-1:0]  number_value;
		logic              number_done;
	} out_item_t;

	// Flow-control result from the stack unit
	typedef struct packed {
		logic              accepted;
		logic [ADDR_W-1:0] position;
	} flow_res_t;

	// Number decoder result
	typedef struct packed {
		logic [NUM_W-1:0] value;
		logic             done;
	} num_res_t;

endpackage

/* sv/sfs_ctrl.sv */
module sfs_ctrl
	import sfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  in_item_t          item,
	input  logic [ADDR_W-1:0] base_address,
	output flow_res_t         res
);

	logic [ADDR_W-1:0]  pos_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [ADDR_W-1:0]  ret_q [STACK_DEPTH];
	logic [COUNT_W-1:0] cnt_q [STACK_DEPTH];

	logic               full, empty;
	logic [PTR_W-1:0]   top_idx, push_idx;
	logic [DEPTH_W-1:0] top_depth;
	logic [COUNT_W-1:0] cnt_dec;

	// Next-state values
	logic [ADDR_W-1:0]  pos_d;
	logic [DEPTH_W-1:0] depth_d;
	logic               ok;
	logic               clear_all, push_ret, push_cnt, store_cnt;

	assign full      = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign empty     = (depth_q == '0);
	assign top_depth = depth_q - DEPTH_W'(1);
	assign top_idx   = top_depth[PTR_W-1:0];
	assign push_idx  = depth_q[PTR_W-1:0];
	assign cnt_dec   = (cnt_q[top_idx] != '0) ? cnt_q[top_idx] - COUNT_W'(1) : '0;

	// Action decode
	always_comb begin
		pos_d     = pos_q;
		depth_d   = depth_q;
		ok        = 1'b0;
		clear_all = 1'b0;
		push_ret  = 1'b0;
		push_cnt  = 1'b0;
		store_cnt = 1'b0;
		case (item.action)
			ACT_RESTART: begin
				clear_all = 1'b1;
				pos_d     = base_address;
				depth_d   = '0;
				ok        = 1'b1;
			end
			ACT_CALL: begin
				if (!full) begin
					push_ret = 1'b1;
					depth_d  = depth_q + DEPTH_W'(1);
					pos_d    = base_address + item.jump_offset;
					ok       = 1'b1;
				end
			end
			ACT_LOOP_START: begin
				if (!full) begin
					push_ret = 1'b1;
					push_cnt = 1'b1;
					depth_d  = depth_q + DEPTH_W'(1);
					ok       = 1'b1;
				end
			end
			ACT_LOOP_END: begin
				if (!empty) begin
					// count runs out: drop the frame, else loop back
					if (cnt_dec == '0) begin
						depth_d = top_depth;
					end else begin
						store_cnt = 1'b1;
						pos_d     = ret_q[top_idx];
					end
					ok = 1'b1;
				end
			end
			ACT_RETURN: begin
				if (!empty) begin
					depth_d = top_depth;
					pos_d   = ret_q[top_idx];
					ok      = 1'b1;
				end
			end
			ACT_NUMBER: begin
				pos_d = pos_q + ADDR_W'(1);
				ok    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Position and depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			depth_q <= '0;
		end else if (fire) begin
			pos_q   <= pos_d;
			depth_q <= depth_d;
		end
	end

	// Stack storage, cleared as a whole on restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACK_DEPTH; i++) begin
				ret_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (fire) begin
			if (clear_all) begin
				for (int i = 0; i < STACK_DEPTH; i++) begin
					ret_q[i] <= '0;
					cnt_q[i] <= '0;
				end
			end else begin
				if (push_ret) ret_q[push_idx] <= pos_q;
				if (push_cnt) cnt_q[push_idx] <= item.loop_count;
				if (store_cnt) cnt_q[top_idx] <= cnt_dec;
			end
		end
	end

	assign res.accepted = ok;
	assign res.position = pos_d;

endmodule

/* sv/sfs_num.sv */
module sfs_num
	import sfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_item_t item,
	output num_res_t res
);

	logic [NUM_W-1:0]       acc_q, acc_d, acc_shift;
	logic [NUM_BYTES_W-1:0] nbytes_q, nbytes_d, nbytes_inc;
	logic                   more;

	assign more       = item.data_byte[7];
	assign acc_shift  = {acc_q[NUM_W-8:0], item.data_byte[6:0]};
	assign nbytes_inc = nbytes_q + NUM_BYTES_W'(1);

	// One byte of a variable-length number, most significant group first
	always_comb begin
		acc_d     = acc_q;
		nbytes_d  = nbytes_q;
		res.value = '0;
		res.done  = 1'b0;
		if (item.action == ACT_RESTART) begin
			acc_d    = '0;
			nbytes_d = '0;
		end else if (item.action == ACT_NUMBER) begin
			if (nbytes_q == '0) begin
				if (!more) begin
					res.done  = 1'b1;
					res.value = NUM_W'(item.data_byte);
				end else begin
					acc_d    = NUM_W'(item.data_byte[6:0]);
					nbytes_d = NUM_BYTES_W'(1);
				end
			end else begin
				acc_d    = acc_shift;
				nbytes_d = nbytes_inc;
				if (!more) begin
					res.done  = 1'b1;
					res.value = acc_shift;
				end else if (nbytes_inc >= NUM_BYTES_W'(MAX_NUM_BYTES)) begin
					// overflow: still set after the last allowed byte
					res.done = 1'b1;
				end
				if (res.done) begin
					acc_d    = '0;
					nbytes_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			nbytes_q <= '0;
		end else if (fire) begin
			acc_q    <= acc_d;
			nbytes_q <= nbytes_d;
		end
	end

endmodule

/* sv/sequence_flow_stack_top.sv */
// Control-flow unit for a sequence reader: read position, return/loop stack
// and variable-length number decoder. Each transaction carries one action;
// every action yields exactly one result transaction. Throughput is one
// action per cycle unless the receiver stalls; an action passes the input
// register, then the result register, with position, stack depth and stack
// entries updated between them. The user is to write base_address via
// cfg_we/cfg_wdata only while no transaction is in flight (not enforced by
// the block); restart loads it into the position, clears stack and decoder.
module sequence_flow_stack_top
	import sfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata
);

	logic [ADDR_W-1:0] base_q;
	in_item_t          item_s1;
	logic              valid_s1;
	logic              adv;
	logic              in_fire;
	flow_res_t         flow_res;
	num_res_t          num_res;
	out_item_t         out_q;
	logic              out_valid_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_fire  = in_valid && in_ready;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) item_s1 <= in_data;
	end

	sfs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (adv),
		.item         (item_s1),
		.base_address (base_q),
		.res          (flow_res)
	);

	sfs_num u_num (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.res    (num_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.accepted     <= flow_res.accepted;
			out_q.position     <= flow_res.position;
			out_q.number_value <= num_res.value;
			out_q.number_done  <= num_res.done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Input stalls only when both registers are occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with free register");

	// Restart reports the base address as new position
	a_restart_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.action == ACT_RESTART) |=>
		(out_q.accepted && out_q.position == $past(base_q)))
		else $error("restart result mismatch");

	// A completed number is always a successful action
	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.number_done) |-> out_q.accepted)
		else $error("number done without accept");

	// No value is reported unless a number completes
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.number_done) |-> (out_q.number_value == '0))
		else $error("stray number value");

endmodule

/* dv/sequence_flow_stack_checker.sv */
`timescale 1ns / 1ps

// Watches the action and result channels of the flow stack, keeps a shadow copy
// of position, stacks and number decoder, and compares every result transaction
// with the oldest predicted one.
module sequence_flow_stack_checker
	import sfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  in_item_t          in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  out_item_t         out_data,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	output int                fault_count,
	output int                results_pending
);

	// Shadow state
	logic [ADDR_W-1:0]      base_copy;
	logic [ADDR_W-1:0]      read_pos;
	logic [DEPTH_W-1:0]     depth;
	logic [ADDR_W-1:0]      ret_stack [STACK_DEPTH];
	logic [COUNT_W-1:0]     cnt_stack [STACK_DEPTH];
	logic [NUM_W-1:0]       num_accum;
	logic [NUM_BYTES_W-1:0] num_bytes;

	out_item_t expected_results[$];

	task automatic clear_flow_state();
		read_pos  = '0;
		depth     = '0;
		num_accum = '0;
		num_bytes = '0;
		for (int k = 0; k < STACK_DEPTH; k++) begin
			ret_stack[k] = '0;
			cnt_stack[k] = '0;
		end
	endtask

	task automatic note_fault(input string what, input out_item_t want, input out_item_t got);
		if (fault_count < 10) begin
			$display("%0t: %s: expected acc=%0b pos=%h val=%h done=%0b, got acc=%0b pos=%h val=%h done=%0b",
				$realtime, what, want.accepted, want.position, want.number_value,
				want.number_done, got.accepted, got.position, got.number_value,
				got.number_done);
		end
		fault_count++;
	endtask

	// Apply one action to the shadow state and return the result it must produce
	task automatic predict_flow(input in_item_t it, output out_item_t res);
		logic [PTR_W-1:0]   top;
		logic [COUNT_W-1:0] cnt;
		res = '0;
		case (it.action)
			ACT_RESTART: begin
				clear_flow_state();
				read_pos     = base_copy;
				res.accepted = 1'b1;
			end
			ACT_CALL: begin
				if (depth < STACK_DEPTH) begin
					ret_stack[depth[PTR_W-1:0]] = read_pos;
					depth                       = depth + 1'b1;
					read_pos                    = base_copy + it.jump_offset;
					res.accepted                = 1'b1;
				end
			end
			ACT_LOOP_START: begin
				if (depth < STACK_DEPTH) begin
					ret_stack[depth[PTR_W-1:0]] = read_pos;
					cnt_stack[depth[PTR_W-1:0]] = it.loop_count;
					depth                       = depth + 1'b1;
					res.accepted                = 1'b1;
				end
			end
			ACT_LOOP_END: begin
				if (depth != 0) begin
					top = PTR_W'(depth - 1'b1);
					cnt = cnt_stack[top];
					if (cnt != 0)
						cnt = cnt - 1'b1;
					// expired loop drops its entry, otherwise jump back
					if (cnt == 0) begin
						depth = depth - 1'b1;
					end else begin
						cnt_stack[top] = cnt;
						read_pos       = ret_stack[top];
					end
					res.accepted = 1'b1;
				end
			end
			ACT_RETURN: begin
				if (depth != 0) begin
					depth        = depth - 1'b1;
					read_pos     = ret_stack[depth[PTR_W-1:0]];
					res.accepted = 1'b1;
				end
			end
			ACT_NUMBER: begin
				read_pos     = read_pos + 1'b1;
				res.accepted = 1'b1;
				if (num_bytes == 0) begin
					if (!it.data_byte[7]) begin
						res.number_done  = 1'b1;
						res.number_value = NUM_W'(it.data_byte);
					end else begin
						num_accum = NUM_W'(it.data_byte[6:0]);
						num_bytes = NUM_BYTES_W'(1);
					end
				end else begin
					num_accum = {num_accum[NUM_W-8:0], it.data_byte[6:0]};
					num_bytes = num_bytes + 1'b1;
					if (!it.data_byte[7]) begin
						res.number_done  = 1'b1;
						res.number_value = num_accum;
					end else if (num_bytes >= MAX_NUM_BYTES) begin
						// four bytes still continuing: overflow, value forced to zero
						res.number_done = 1'b1;
					end
					if (res.number_done) begin
						num_accum = '0;
						num_bytes = '0;
					end
				end
			end
			default: begin
				// spare action codes do nothing
			end
		endcase
		res.position = read_pos;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			base_copy = '0;
			clear_flow_state();
			expected_results.delete();
			fault_count     = 0;
			results_pending <= 0;
		end else begin
			// compare a result transaction with the oldest prediction
			if (out_valid && out_ready) begin
				got = out_data;
				if (expected_results.size() == 0) begin
					note_fault("unexpected result", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got.accepted !== want.accepted || got.position !== want.position ||
						got.number_value !== want.number_value ||
						got.number_done !== want.number_done)
						note_fault("result mismatch", want, got);
				end
			end
			if (cfg_we)
				base_copy = cfg_wdata;
			// predict the result of an accepted action transaction
			if (in_valid && in_ready) begin
				predict_flow(in_data, want);
				expected_results.push_back(want);
			end
			results_pending <= expected_results.size();
		end
	end

endmodule

/* dv/sequence_flow_stack_top_tb.sv */
`timescale 1ns / 1ps

module sequence_flow_stack_top_tb;
	import sfs_pkg::*;

	// action codes the block does not define
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 250;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	in_item_t          in_data;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;

	int fault_count;
	int results_pending;
	int cycle_count = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int items_sent  = 0;

	logic [ADDR_W-1:0] phase_base [4];
	int                phase_idle [4];
	int                phase_stall [4];

	sequence_flow_stack_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sequence_flow_stack_checker flow_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.fault_count     (fault_count),
		.results_pending (results_pending)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sequence_flow_stack_top_tb NOT OK");
			$finish;
		end
	end

	function automatic in_item_t make_item(input logic [2:0] act, input logic [ADDR_W-1:0] ofs,
		input logic [COUNT_W-1:0] cnt, input logic [7:0] data);
		in_item_t it;
		it.action      = act;
		it.jump_offset = ofs;
		it.loop_count  = cnt;
		it.data_byte   = data;
		return it;
	endfunction

	// Present one action transaction; called and returns at a falling edge
	task automatic send_action(input in_item_t it);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_push();
		logic [COUNT_W-1:0] cnt;
		logic [ADDR_W-1:0]  ofs;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: cnt = COUNT_W'($urandom_range(3));
			9:                cnt = '1;
			default:          cnt = COUNT_W'($urandom_range(65535));
		endcase
		case ($urandom_range(9))
			0:       ofs = '0;
			1:       ofs = '1;
			default: ofs = $urandom();
		endcase
		if ($urandom_range(1))
			send_action(make_item(ACT_CALL, ofs, COUNT_W'($urandom_range(65535)),
				8'($urandom_range(255))));
		else
			send_action(make_item(ACT_LOOP_START, ofs, cnt, 8'($urandom_range(255))));
	endtask

	task automatic send_pop();
		send_action(make_item(($urandom_range(9) < 6) ? ACT_LOOP_END : ACT_RETURN, $urandom(),
			COUNT_W'($urandom_range(65535)), 8'($urandom_range(255))));
	endtask

	// Well-formed variable-length number with occasional noise and interruptions
	task automatic send_number();
		int         len;
		logic [7:0] data;
		len = $urandom_range(1, 4);
		for (int k = 0; k < len; k++) begin
			data = 8'($urandom_range(255));
			if (k == len - 1)
				data[7] = (len == 4) && ($urandom_range(4) == 0);
			else
				data[7] = 1'b1;
			if ($urandom_range(19) == 0)
				data = 8'($urandom_range(255));
			if ($urandom_range(19) == 0)
				send_pop();
			send_action(make_item(ACT_NUMBER, $urandom(), COUNT_W'($urandom_range(65535)),
				data));
		end
	endtask

	task automatic run_random(input int quota);
		int stop_at;
		int pick;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 2)
				send_action(make_item(ACT_RESTART, $urandom(), COUNT_W'($urandom_range(65535)),
					8'($urandom_range(255))));
			else if (pick < 4)
				send_action(make_item($urandom_range(1) ? ACT_SPARE_7 : ACT_SPARE_6, $urandom(),
					COUNT_W'($urandom_range(65535)), 8'($urandom_range(255))));
			else if (pick < 7)
				// drive the stack into its full condition
				repeat ($urandom_range(9, 11)) send_push();
			else if (pick < 40)
				send_push();
			else if (pick < 70)
				send_pop();
			else
				send_number();
		end
	endtask

	// Drop valid and wait until every result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		wait (results_pending == 0);
		@(negedge clk);
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		phase_base  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000};
		phase_idle  = '{0, 64, 0, 35};
		phase_stall = '{0, 0, 64, 35};
		phase_base[2] = $urandom();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: base near the top so calls wrap
		write_base(32'hFFFF_FFF0);
		send_action(make_item(ACT_RESTART, '1, '1, 8'hFF));
		send_action(make_item(ACT_RETURN, '0, '0, 8'h00));
		send_action(make_item(ACT_LOOP_END, '0, '0, 8'h00));
		send_action(make_item(ACT_NUMBER, '0, '0, 8'h00));
		send_action(make_item(ACT_NUMBER, '0, '0, 8'h7F));
		// largest four-byte number
		send_action(make_item(ACT_NUMBER, '0, '0, 8'hFF));
		send_action(make_item(ACT_NUMBER, '0, '0, 8'hFF));
		send_action(make_item(ACT_NUMBER, '0, '0, 8'hFF));
		send_action(make_item(ACT_NUMBER, '0, '0, 8'h7F));
		// four continuation bytes: overflow
		send_action(make_item(ACT_NUMBER, '0, '0, 8'h80));
		send_action(make_item(ACT_NUMBER, '0, '0, 8'h80));
		send_action(make_item(ACT_NUMBER, '0, '0, 8'h80));
		send_action(make_item(ACT_NUMBER, '0, '0, 8'h80));
		// zero count loop pops at once, full count jumps back
		send_action(make_item(ACT_LOOP_START, '0, '0, 8'h00));
		send_action(make_item(ACT_LOOP_END, '0, '0, 8'h00));
		send_action(make_item(ACT_LOOP_START, '1, '1, 8'h00));
		// number left pending across other actions
		send_action(make_item(ACT_NUMBER, '0, '0, 8'h85));
		send_action(make_item(ACT_LOOP_END, '0, '0, 8'h00));
		send_action(make_item(ACT_CALL, '1, '0, 8'h00));
		send_action(make_item(ACT_NUMBER, '0, '0, 8'h01));
		send_action(make_item(ACT_RETURN, '0, '0, 8'h00));
		send_action(make_item(ACT_SPARE_6, '1, '1, 8'hFF));
		send_action(make_item(ACT_SPARE_7, '1, '1, 8'hFF));
		send_action(make_item(ACT_CALL, '0, '1, 8'h00));
		send_action(make_item(ACT_RESTART, '0, '0, 8'h00));
		wait_idle();

		// random phases, each with its own base and idling mix
		for (int p = 0; p < 4; p++) begin
			write_base(phase_base[p]);
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			run_random(ITEMS_PER_PHASE);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("sequence_flow_stack_top_tb OK");
		else
			$display("sequence_flow_stack_top_tb NOT OK");
		$finish;
	end

endmodule

/* files.f */
sv/sfs_pkg.sv
sv/sfs_ctrl.sv
sv/sfs_num.sv
sv/sequence_flow_stack_top.sv
dv/sequence_flow_stack_checker.sv
dv/sequence_flow_stack_top_tb.sv
